// ----- hw/rtl/cpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants, types and codes for the convex polygon point test core.
// ----------------------------------------------------------------------------
package cpt_pkg;

    // table and coordinate sizing
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int MIN_VERTICES = 3;

    // fixed field widths
    localparam int VCOUNT_BITS = 7;
    localparam int INDEX_BITS  = 6;

    // derived widths
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int CROSS_BITS   = PROD_BITS + 1;
    // iterations needed for a fan of up to MAX_VERTICES-2 candidates
    localparam int SEARCH_STEPS = $clog2(MAX_VERTICES - 1);

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(MIN_VERTICES);

    // transaction modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;
    typedef logic [IDX_BITS-1:0]          vidx_t;

    // query state carried down the pipeline
    typedef struct packed {
        logic   outside;
        coord_t px;
        coord_t py;
        diff_t  wx;
        diff_t  wy;
        vidx_t  lo;
        vidx_t  hi;
        vidx_t  best;
    } cpt_query_t;

    // vertex table write, broadcast to every table copy
    typedef struct packed {
        logic   en;
        vidx_t  addr;
        coord_t x;
        coord_t y;
    } cpt_wr_t;

endpackage

// ----- hw/rtl/convex_polygon_point_test_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_polygon_point_test_core
// Point in convex polygon test: wedge check at the pivot, pipelined binary
// search over the fan, then a test against the found edge.
//
// channel | ports                                     | dir | carries
// s_      | s_valid s_ready s_mode s_index s_x s_y    | in  | vertex load or query
// m_      | m_valid m_ready m_inside_res              | out | one per query
// cfg_    | cfg_wr_en cfg_wr_data                     | in  | vertex count
//
// one transaction per cycle while the output does not stall; m_valid for a query
// is set through the wedge and edge stages, the fan search stages of three
// registers each and the output register. a load is taken only with no query
// in flight. a stalled output freezes the whole pipeline; nothing is lost.
// reset clears the valid bits and sets the vertex count to 3; vertex tables
// are not cleared.
// ----------------------------------------------------------------------------
module convex_polygon_point_test_core
    import cpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [VCOUNT_BITS-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_mode,
    input  logic [INDEX_BITS-1:0]  s_index,
    input  coord_t                 s_x,
    input  coord_t                 s_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_inside_res
);

    // vertex count register and clamp
    logic [VCOUNT_BITS-1:0] vcount_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    logic [CNT_BITS-1:0] n_use;
    always_comb begin
        if (int'(vcount_reg) < MIN_VERTICES) begin
            n_use = CNT_BITS'(MIN_VERTICES);
        end else if (int'(vcount_reg) > MAX_VERTICES) begin
            n_use = CNT_BITS'(MAX_VERTICES);
        end else begin
            n_use = CNT_BITS'(vcount_reg);
        end
    end

    vidx_t n_last;
    vidx_t hi_init;
    assign n_last  = IDX_BITS'(n_use - CNT_BITS'(1));
    assign hi_init = IDX_BITS'(n_use - CNT_BITS'(2));

    // handshake
    logic m_valid_reg;
    logic m_inside_res_reg;
    logic adv;
    logic busy;
    logic s_acc;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && (s_mode == MODE_QUERY || !busy);
    assign s_acc   = s_valid && s_ready;

    // vertex write broadcast
    cpt_wr_t wr;
    always_comb begin
        wr.en   = s_acc && s_mode == MODE_LOAD && int'(s_index) < MAX_VERTICES;
        wr.addr = IDX_BITS'(s_index);
        wr.x    = s_x;
        wr.y    = s_y;
    end

    // pivot and first vertex kept in registers
    coord_t v0x_reg, v0y_reg, v1x_reg, v1y_reg;
    always_ff @(posedge aclk) begin
        if (wr.en && wr.addr == vidx_t'(0)) begin
            v0x_reg <= wr.x;
            v0y_reg <= wr.y;
        end
        if (wr.en && wr.addr == vidx_t'(1)) begin
            v1x_reg <= wr.x;
            v1y_reg <= wr.y;
        end
    end

    // table copies for the wedge and the edge test
    coord_t wmem_x [MAX_VERTICES];
    coord_t wmem_y [MAX_VERTICES];
    coord_t emem_x [MAX_VERTICES];
    coord_t emem_y [MAX_VERTICES];
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            wmem_x[wr.addr] <= wr.x;
            wmem_y[wr.addr] <= wr.y;
            emem_x[wr.addr] <= wr.x;
            emem_y[wr.addr] <= wr.y;
        end
    end

    // wedge stage 1: offsets from pivot, read last vertex
    logic   w1_valid_reg;
    coord_t w1_px_reg, w1_py_reg, w1_vlx_reg, w1_vly_reg;
    diff_t  w1_wx_reg, w1_wy_reg;
    vidx_t  w1_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_valid_reg <= 1'b0;
        end else if (adv) begin
            w1_valid_reg <= s_acc && s_mode == MODE_QUERY;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w1_px_reg  <= s_x;
            w1_py_reg  <= s_y;
            w1_wx_reg  <= diff_t'(s_x) - diff_t'(v0x_reg);
            w1_wy_reg  <= diff_t'(s_y) - diff_t'(v0y_reg);
            w1_vlx_reg <= wmem_x[n_last];
            w1_vly_reg <= wmem_y[n_last];
            w1_hi_reg  <= hi_init;
        end
    end

    // wedge stage 2: products for both wedge edges
    diff_t uax, uay, ubx, uby;
    assign uax = diff_t'(v1x_reg) - diff_t'(v0x_reg);
    assign uay = diff_t'(v1y_reg) - diff_t'(v0y_reg);
    assign ubx = diff_t'(w1_vlx_reg) - diff_t'(v0x_reg);
    assign uby = diff_t'(w1_vly_reg) - diff_t'(v0y_reg);

    logic   w2_valid_reg;
    coord_t w2_px_reg, w2_py_reg;
    diff_t  w2_wx_reg, w2_wy_reg;
    vidx_t  w2_hi_reg;
    prod_t  w2_a1_reg, w2_a2_reg, w2_b1_reg, w2_b2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w2_valid_reg <= 1'b0;
        end else if (adv) begin
            w2_valid_reg <= w1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w2_px_reg <= w1_px_reg;
            w2_py_reg <= w1_py_reg;
            w2_wx_reg <= w1_wx_reg;
            w2_wy_reg <= w1_wy_reg;
            w2_hi_reg <= w1_hi_reg;
            w2_a1_reg <= uax * w1_wy_reg;
            w2_a2_reg <= uay * w1_wx_reg;
            w2_b1_reg <= ubx * w1_wy_reg;
            w2_b2_reg <= uby * w1_wx_reg;
        end
    end

    // wedge stage 3: reject outside the wedge, seed the search
    cross_t     ca, cb;
    cpt_query_t w3_item_next;
    assign ca = cross_t'(w2_a1_reg) - cross_t'(w2_a2_reg);
    assign cb = cross_t'(w2_b1_reg) - cross_t'(w2_b2_reg);

    always_comb begin
        w3_item_next.outside = ca[CROSS_BITS-1] || (!cb[CROSS_BITS-1] && cb != cross_t'(0));
        w3_item_next.px      = w2_px_reg;
        w3_item_next.py      = w2_py_reg;
        w3_item_next.wx      = w2_wx_reg;
        w3_item_next.wy      = w2_wy_reg;
        w3_item_next.lo      = vidx_t'(1);
        w3_item_next.hi      = w2_hi_reg;
        w3_item_next.best    = vidx_t'(1);
    end

    logic       w3_valid_reg;
    cpt_query_t w3_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w3_valid_reg <= 1'b0;
        end else if (adv) begin
            w3_valid_reg <= w2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w3_item_reg <= w3_item_next;
        end
    end

    // fan search chain
    logic       chain_valid [SEARCH_STEPS+1];
    cpt_query_t chain_item  [SEARCH_STEPS+1];
    logic [SEARCH_STEPS-1:0] step_busy;

    assign chain_valid[0] = w3_valid_reg;
    assign chain_item[0]  = w3_item_reg;

    for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_step
        cpt_fan_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .wr        (wr),
            .v0_x      (v0x_reg),
            .v0_y      (v0y_reg),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1]),
            .busy      (step_busy[g])
        );
    end

    cpt_query_t srch;
    assign srch = chain_item[SEARCH_STEPS];

    // edge stage 1: read both ends of the found edge
    logic   e1_valid_reg, e1_out_reg;
    coord_t e1_px_reg, e1_py_reg;
    coord_t e1_ax_reg, e1_ay_reg, e1_bx_reg, e1_by_reg;
    vidx_t  best_nx;
    assign best_nx = srch.best + vidx_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else if (adv) begin
            e1_valid_reg <= chain_valid[SEARCH_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_out_reg <= srch.outside;
            e1_px_reg  <= srch.px;
            e1_py_reg  <= srch.py;
            e1_ax_reg  <= emem_x[srch.best];
            e1_ay_reg  <= emem_y[srch.best];
            e1_bx_reg  <= emem_x[best_nx];
            e1_by_reg  <= emem_y[best_nx];
        end
    end

    // edge stage 2: products for the edge cross
    diff_t ex, ey, qx, qy;
    assign ex = diff_t'(e1_bx_reg) - diff_t'(e1_ax_reg);
    assign ey = diff_t'(e1_by_reg) - diff_t'(e1_ay_reg);
    assign qx = diff_t'(e1_px_reg) - diff_t'(e1_bx_reg);
    assign qy = diff_t'(e1_py_reg) - diff_t'(e1_by_reg);

    logic  e2_valid_reg, e2_out_reg;
    prod_t e2_p1_reg, e2_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg <= 1'b0;
        end else if (adv) begin
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e2_out_reg <= e1_out_reg;
            e2_p1_reg  <= ex * qy;
            e2_p2_reg  <= ey * qx;
        end
    end

    // edge stage 3: final decision into the output register
    cross_t ce;
    logic   inside_next;
    assign ce          = cross_t'(e2_p1_reg) - cross_t'(e2_p2_reg);
    assign inside_next = !e2_out_reg && !ce[CROSS_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_inside_res_reg <= inside_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_res_reg;

    // queries still in flight
    assign busy = w1_valid_reg | w2_valid_reg | w3_valid_reg | (|step_busy)
                | e1_valid_reg | e2_valid_reg;

    // a load never overtakes a query in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_LOAD |-> !busy)
        else $error("vertex load accepted with queries in flight");

    // a finished query reaches the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && e2_valid_reg |=> m_valid_reg)
        else $error("query result lost at output");

    // stall holds the pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(w1_valid_reg) && $stable(e2_valid_reg) && m_valid_reg)
        else $error("pipeline moved during stall");

endmodule

// ----- hw/rtl/cpt_fan_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_fan_step
// One binary search iteration over the fan at the pivot: reads the middle
// vertex from a private table copy, forms the cross product and narrows the
// search range. Three register stages.
// ----------------------------------------------------------------------------
module cpt_fan_step
    import cpt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  cpt_wr_t    wr,
    input  coord_t     v0_x,
    input  coord_t     v0_y,
    input  logic       in_valid,
    input  cpt_query_t in_item,
    output logic       out_valid,
    output cpt_query_t out_item,
    output logic       busy
);

    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];

    // table copy write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem_x[wr.addr] <= wr.x;
            mem_y[wr.addr] <= wr.y;
        end
    end

    // stage a: midpoint and table read
    logic [IDX_BITS:0] mid_sum;
    vidx_t             mid;
    assign mid_sum = {1'b0, in_item.lo} + {1'b0, in_item.hi};
    assign mid     = mid_sum[IDX_BITS:1];

    logic       a_valid_reg;
    cpt_query_t a_item_reg;
    logic       a_act_reg;
    vidx_t      a_mid_reg;
    coord_t     a_vx_reg;
    coord_t     a_vy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_item_reg <= in_item;
            a_act_reg  <= (in_item.lo <= in_item.hi);
            a_mid_reg  <= mid;
            a_vx_reg   <= mem_x[mid];
            a_vy_reg   <= mem_y[mid];
        end
    end

    // stage b: edge vector from pivot and products
    diff_t ux;
    diff_t uy;
    assign ux = diff_t'(a_vx_reg) - diff_t'(v0_x);
    assign uy = diff_t'(a_vy_reg) - diff_t'(v0_y);

    logic       b_valid_reg;
    cpt_query_t b_item_reg;
    logic       b_act_reg;
    vidx_t      b_mid_reg;
    prod_t      b_p1_reg;
    prod_t      b_p2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_item_reg <= a_item_reg;
            b_act_reg  <= a_act_reg;
            b_mid_reg  <= a_mid_reg;
            b_p1_reg   <= ux * a_item_reg.wy;
            b_p2_reg   <= uy * a_item_reg.wx;
        end
    end

    // stage c: sign of cross product narrows the range
    cross_t     cross_val;
    cpt_query_t c_item_next;
    assign cross_val = cross_t'(b_p1_reg) - cross_t'(b_p2_reg);

    always_comb begin
        c_item_next = b_item_reg;
        if (b_act_reg) begin
            if (!cross_val[CROSS_BITS-1]) begin
                c_item_next.best = b_mid_reg;
                c_item_next.lo   = b_mid_reg + vidx_t'(1);
            end else begin
                c_item_next.hi   = b_mid_reg - vidx_t'(1);
            end
        end
    end

    logic       c_valid_reg;
    cpt_query_t c_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;
    assign busy      = a_valid_reg | b_valid_reg | c_valid_reg;

    // midpoint stays within an active range
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && a_act_reg |-> a_mid_reg >= a_item_reg.lo && a_mid_reg <= a_item_reg.hi)
        else $error("fan step midpoint outside search range");

    // range never crosses by more than one
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> {1'b0, c_item_reg.lo} <= {1'b0, c_item_reg.hi} + (IDX_BITS+1)'(1))
        else $error("fan step range collapsed past empty");

    // stall freezes the result stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !adv |=> c_valid_reg && $stable(c_item_reg))
        else $error("fan step result changed during stall");

endmodule

// ----- dv/tb_convex_polygon_point_test_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_test_core
// Loads convex polygons of several sizes, including the smallest and largest
// vertex counts, and sends query points inside, outside and on the boundary.
// Every answer is checked against a local predictor that runs the same wedge
// check, fan search and edge test, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_convex_polygon_point_test_core;
    import cpt_pkg::*;

    localparam int LATENCY     = 3 * (SEARCH_STEPS + 2) + 1;
    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [VCOUNT_BITS-1:0] cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_mode;
    logic [INDEX_BITS-1:0]  s_index;
    coord_t                 s_x;
    coord_t                 s_y;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_inside_res;

    // predictor state
    longint poly_x[MAX_VERTICES];
    longint poly_y[MAX_VERTICES];
    int     poly_count;

    bit     inside_expected[$];
    int     mismatches;
    int     cycle_count;
    int     queries_checked;
    int     loads_sent;
    bit     hold_off;
    int     burst_left;

    convex_polygon_point_test_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_index      (s_index),
        .s_x          (s_x),
        .s_y          (s_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    // clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_convex_polygon_point_test_core NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // cross(b - a, p - c)
    function automatic longint fan_cross(int a, int b, int c, longint px, longint py);
        return (poly_x[b] - poly_x[a]) * (py - poly_y[c])
             - (poly_y[b] - poly_y[a]) * (px - poly_x[c]);
    endfunction

    function automatic bit point_inside(longint px, longint py);
        int n;
        int lo;
        int hi;
        int best;
        int mid;
        n = poly_count;
        if (n < MIN_VERTICES) n = MIN_VERTICES;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        if (fan_cross(0, 1, 0, px, py) < 0 || fan_cross(0, n - 1, 0, px, py) > 0)
            return 1'b0;
        lo = 1;
        hi = n - 2;
        best = 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (fan_cross(0, mid, 0, px, py) >= 0) begin
                best = mid;
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return fan_cross(best, best + 1, best + 1, px, py) >= 0;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (inside_expected.size() == 0) begin
                report_mismatch("unexpected result", m_inside_res, -1);
            end else begin
                if (m_inside_res !== inside_expected[0])
                    report_mismatch("inside_res", m_inside_res, inside_expected[0]);
                void'(inside_expected.pop_front());
                queries_checked++;
            end
        end
    end

    // receiver stall pattern, overridden by the long hold-off
    always @(negedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else if (cycle_count[9:7] == 3'd5)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    // send one transaction; gaps come in bursts
    task automatic send_item(input bit mode, input int slot, input int px, input int py);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_index <= slot[INDEX_BITS-1:0];
        s_x     <= px[COORD_BITS-1:0];
        s_y     <= py[COORD_BITS-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (mode == MODE_LOAD) begin
            poly_x[slot] = longint'(coord_t'(px));
            poly_y[slot] = longint'(coord_t'(py));
            loads_sent++;
        end else begin
            inside_expected.push_back(point_inside(longint'(coord_t'(px)),
                                                   longint'(coord_t'(py))));
        end
        @(negedge aclk);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (inside_expected.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_count(input int n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n[VCOUNT_BITS-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        poly_count = n;
    endtask

    // regular polygon of n vertices around (cx, cy), counter-clockwise
    task automatic load_polygon(input int n, input int cx, input int cy, input int r);
        real a;
        real rot;
        rot = $urandom_range(0, 628) / 100.0;
        for (int i = 0; i < n; i++) begin
            a = rot + 6.283185307 * i / n;
            send_item(MODE_LOAD, i, cx + $rtoi(r * $cos(a)), cy + $rtoi(r * $sin(a)));
        end
    endtask

    function automatic int rand_coord();
        return $signed($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // queries near the polygon plus vertices, edge midpoints and noise
    task automatic random_queries(input int count, input int n, input int cx,
                                  input int cy, input int r);
        int sel;
        int k;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 9);
            k = $urandom_range(0, n - 1);
            if (sel < 6)
                send_item(MODE_QUERY, $urandom_range(0, 63),
                          clamp_coord(cx + $signed($urandom_range(0, 3 * r)) - 3 * r / 2),
                          clamp_coord(cy + $signed($urandom_range(0, 3 * r)) - 3 * r / 2));
            else if (sel < 7)
                send_item(MODE_QUERY, 0, int'(poly_x[k]), int'(poly_y[k]));
            else if (sel < 8)
                send_item(MODE_QUERY, 0,
                          int'((poly_x[k] + poly_x[(k + 1) % n]) / 2),
                          int'((poly_y[k] + poly_y[(k + 1) % n]) / 2));
            else
                send_item(MODE_QUERY, $urandom_range(0, 63), rand_coord(), rand_coord());
        end
    endtask

    // extremes: a triangle using the full coordinate range
    task automatic test_extreme_triangle();
        write_count(3);
        send_item(MODE_LOAD, 0, -32768, -32768);
        send_item(MODE_LOAD, 1, 32767, -32768);
        send_item(MODE_LOAD, 2, -32768, 32767);
        send_item(MODE_QUERY, 63, -32768, -32768);
        send_item(MODE_QUERY, 0, 32767, 32767);
        send_item(MODE_QUERY, 5, 0, 0);
        send_item(MODE_QUERY, 0, -1, -1);
        send_item(MODE_QUERY, 0, 32767, -32768);
        send_item(MODE_QUERY, 0, -32768, 0);
        send_item(MODE_QUERY, 0, 0, -32768);
        drain_outputs();
    endtask

    // degenerate and clockwise data, boundary points of a square
    task automatic test_special_shapes();
        write_count(4);
        send_item(MODE_LOAD, 0, 0, 0);
        send_item(MODE_LOAD, 1, 100, 0);
        send_item(MODE_LOAD, 2, 100, 100);
        send_item(MODE_LOAD, 3, 0, 100);
        send_item(MODE_QUERY, 0, 50, 0);
        send_item(MODE_QUERY, 0, 100, 50);
        send_item(MODE_QUERY, 0, 50, 101);
        send_item(MODE_QUERY, 0, 50, 50);
        drain_outputs();
        // collinear vertices
        send_item(MODE_LOAD, 1, 10, 10);
        send_item(MODE_LOAD, 2, 20, 20);
        send_item(MODE_LOAD, 3, 30, 30);
        send_item(MODE_QUERY, 0, 15, 15);
        send_item(MODE_QUERY, 0, 15, 16);
        // clockwise order
        send_item(MODE_LOAD, 1, 0, 100);
        send_item(MODE_LOAD, 2, 100, 100);
        send_item(MODE_LOAD, 3, 100, 0);
        send_item(MODE_QUERY, 0, 50, 50);
        send_item(MODE_QUERY, 0, -50, 50);
        drain_outputs();
        // out of range counts clamp to 3
        write_count(0);
        send_item(MODE_QUERY, 0, 50, 50);
        drain_outputs();
        write_count(2);
        send_item(MODE_QUERY, 0, 99, 1);
        drain_outputs();
    endtask

    // random polygons at several sizes, largest included
    task automatic test_random_polygons();
        int sizes[8] = '{3, 64, 5, 8, 17, 33, 4, 64};
        int n;
        int cx;
        int cy;
        int r;
        for (int p = 0; p < 8; p++) begin
            n = sizes[p];
            r = $urandom_range(50, 12000);
            cx = $signed($urandom_range(0, 30000)) - 15000;
            cy = $signed($urandom_range(0, 30000)) - 15000;
            drain_outputs();
            write_count(n);
            load_polygon(n, cx, cy, r);
            random_queries(60, n, cx, cy, r);
        end
        // counts above the table depth clamp to 64
        drain_outputs();
        write_count(127);
        random_queries(40, 64, cx, cy, r);
        drain_outputs();
        write_count(100);
        random_queries(30, 64, cx, cy, r);
    endtask

    // receiver holds off while queries keep coming
    task automatic test_backpressure();
        drain_outputs();
        write_count(6);
        load_polygon(6, 0, 0, 1000);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end
            random_queries(70, 6, 0, 0, 1000);
        join
        drain_outputs();
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_mode      = MODE_LOAD;
        s_index     = '0;
        s_x         = '0;
        s_y         = '0;
        m_ready     = 1'b0;
        hold_off    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        queries_checked = 0;
        loads_sent  = 0;
        burst_left  = 0;
        poly_count  = 3;
        foreach (poly_x[i]) begin
            poly_x[i] = 0;
            poly_y[i] = 0;
        end
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_extreme_triangle();
        test_special_shapes();
        test_random_polygons();
        test_backpressure();
        drain_outputs();

        $display("covered %0d vertex loads and %0d checked queries over counts 3..64",
                 loads_sent, queries_checked);
        $display("including clamped counts, degenerate and clockwise data, long stall");
        if (mismatches == 0)
            $display("tb_convex_polygon_point_test_core OK");
        else
            $display("tb_convex_polygon_point_test_core NOT OK");
        $finish;
    end

endmodule
